// ===== hw/rtl/mono_framebuffer_blitter_macros.svh =====
// assertion helpers, clocked on clk_i and off while rst_ni is low
`ifndef MONO_FRAMEBUFFER_BLITTER_MACROS_SVH
`define MONO_FRAMEBUFFER_BLITTER_MACROS_SVH

// same-cycle implication
`define MFB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mfb_pkg.sv =====
package mfb_pkg;

  localparam int DISP_WIDTH_DEF  = 800;
  localparam int DISP_HEIGHT_DEF = 480;

  // largest store over the parameter range is 512 * 4096 bytes
  localparam int FB_ADDR_W   = 21;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] FILL_WHITE = 8'hFF;

  typedef enum logic [1:0] {
    REQ_BLIT  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_BLIT  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] dest_x;
    logic [15:0] dest_y;
    logic [15:0] img_width;
    logic [15:0] img_height;
    logic [15:0] src_row;
    logic [12:0] src_byte_col;
    logic [7:0]  data_byte;
    logic [15:0] read_addr;
  } mfb_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] pixels_drawn;
  } mfb_out_t;

  // one classified command; wmask/wdata span two neighbor bytes, byte 0 on top
  typedef struct packed {
    op_e                  op;
    logic [FB_ADDR_W-1:0] addr;
    logic [15:0]          wmask;
    logic [15:0]          wdata;
    logic [3:0]           count;
  } mfb_cmd_t;

  typedef struct packed {
    logic init_busy;
  } mfb_status_t;

endpackage

// ===== hw/rtl/mfb_ram.sv =====
module mfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mfb_front.sv =====
module mfb_front
  import mfb_pkg::*;
#(
  parameter int DISP_WIDTH  = DISP_WIDTH_DEF,
  parameter int DISP_HEIGHT = DISP_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  mfb_in_t     in_data_i,
  input  mfb_status_t status_i,
  output logic        push_o,
  input  logic        full_i,
  output mfb_cmd_t    cmd_o
);

  localparam int RowBytes   = (DISP_WIDTH + 7) / 8;
  localparam int StoreBytes = RowBytes * DISP_HEIGHT;
  localparam logic [16:0] PxLimit = 17'(DISP_WIDTH);
  localparam logic [16:0] PyLimit = 17'(DISP_HEIGHT);
  localparam logic [FB_ADDR_W-1:0] RowBytesW = FB_ADDR_W'(RowBytes);

  logic        accept;
  logic [16:0] py;
  logic        row_ok;
  logic [15:0] col_base;
  logic [16:0] px0;
  logic [15:0] col [8];
  logic [16:0] px [8];
  logic [7:0]  vmask;

  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  s1_req_q;
  logic [16:0] s1_py_q;
  logic [16:0] s1_px0_q;
  logic [7:0]  s1_vmask_q;
  logic [7:0]  s1_data_q;
  logic [15:0] s1_raddr_q;

  logic [FB_ADDR_W-1:0] row_base;
  logic [3:0]           pix_cnt;
  mfb_cmd_t             cmd;

  assign in_stall_o = status_i.init_busy || (s1_valid_q && full_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = s1_valid_q && !full_i;

  // per-pixel clipping of the incoming beat
  always_comb begin
    py       = {1'b0, in_data_i.dest_y} + {1'b0, in_data_i.src_row};
    row_ok   = (in_data_i.src_row < in_data_i.img_height) && (py < PyLimit);
    col_base = {in_data_i.src_byte_col, 3'b000};
    px0      = {1'b0, in_data_i.dest_x} + {1'b0, col_base};
    for (int i = 0; i < 8; i++) begin
      col[i] = col_base + 16'(i);
      px[i]  = {1'b0, in_data_i.dest_x} + {1'b0, col[i]};
      vmask[7-i] = row_ok && (col[i] < in_data_i.img_width) && (px[i] < PxLimit);
    end
  end

  assign s1_valid_d = accept ? 1'b1 : (push_o ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q   <= in_data_i.req_type;
      s1_py_q    <= py;
      s1_px0_q   <= px0;
      s1_vmask_q <= vmask;
      s1_data_q  <= in_data_i.data_byte;
      s1_raddr_q <= in_data_i.read_addr;
    end
  end

  // address, byte-pair masks and pixel count
  always_comb begin
    row_base = FB_ADDR_W'(s1_py_q) * RowBytesW;
    pix_cnt  = 4'd0;
    for (int i = 0; i < 8; i++) begin
      pix_cnt = pix_cnt + {3'b000, s1_vmask_q[i]};
    end
    cmd = '0;
    case (s1_req_q)
      REQ_BLIT: begin
        cmd.op    = OP_BLIT;
        cmd.addr  = row_base + FB_ADDR_W'(s1_px0_q >> 3);
        cmd.wmask = {s1_vmask_q, 8'h00} >> s1_px0_q[2:0];
        cmd.wdata = {s1_data_q, 8'h00} >> s1_px0_q[2:0];
        cmd.count = pix_cnt;
      end
      REQ_CLEAR: begin
        cmd.op    = OP_CLEAR;
        cmd.wdata = {s1_data_q, 8'h00};
      end
      REQ_READ: begin
        cmd.op   = (32'(s1_raddr_q) < StoreBytes) ? OP_READ : OP_NOP;
        cmd.addr = FB_ADDR_W'(s1_raddr_q);
      end
      default: begin
        cmd.op = OP_NOP;
      end
    endcase
  end

  assign cmd_o = cmd;

endmodule

// ===== hw/rtl/mfb_queue.sv =====
`include "mono_framebuffer_blitter_macros.svh"

module mfb_queue
  import mfb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  mfb_cmd_t cmd_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output mfb_cmd_t cmd_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  mfb_cmd_t        slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  `MFB_ASSERT_IMP(a_no_push_full, push_i, !full_o, "push into full queue")
  `MFB_ASSERT_IMP(a_no_pop_empty, pop_i, valid_o, "pop from empty queue")
  `MFB_ASSERT_NXT(a_cnt_up, push_i && !pop_i, cnt_q == CntW'($past(cnt_q) + 1'b1),
                  "queue count did not grow on push")

endmodule

// ===== hw/rtl/mfb_back.sv =====
`include "mono_framebuffer_blitter_macros.svh"

module mfb_back
  import mfb_pkg::*;
#(
  parameter int STORE_BYTES = ((DISP_WIDTH_DEF + 7) / 8) * DISP_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  mfb_cmd_t    q_data_i,
  output logic        q_pop_o,
  output mfb_status_t status_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output mfb_out_t    out_data_o
);

  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(STORE_BYTES - 1);

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_RD0    = 7'b0000100,
    ST_WR1    = 7'b0001000,
    ST_CLR    = 7'b0010000,
    ST_RDWAIT = 7'b0100000,
    ST_DONE   = 7'b1000000
  } bst_e;

  bst_e     state_q, state_d;
  mfb_cmd_t cmd_q, cmd_d;
  logic [AW-1:0] sweep_q, sweep_d;
  mfb_out_t res_q, res_d;
  logic     out_valid_q, out_valid_d;
  mfb_out_t out_q, out_d;

  logic          res_ready;
  logic [AW-1:0] q_addr;
  logic [AW-1:0] cmd_addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  mfb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_ready          = !out_valid_q || !out_stall_i;
  assign q_addr             = q_data_i.addr[AW-1:0];
  assign cmd_addr           = cmd_q.addr[AW-1:0];
  assign status_o.init_busy = (state_q == ST_INIT);
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    sweep_d     = sweep_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = FILL_WHITE;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == LastAddr) begin
          sweep_d = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_data_i;
          res_d.read_data    = 8'h00;
          res_d.pixels_drawn = q_data_i.count;
          case (q_data_i.op)
            OP_BLIT: begin
              if (q_data_i.wmask[15:8] != 8'h00) begin
                ram_re    = 1'b1;
                ram_raddr = q_addr;
                state_d   = ST_RD0;
              end else if (q_data_i.wmask[7:0] != 8'h00) begin
                ram_re    = 1'b1;
                ram_raddr = q_addr + 1'b1;
                state_d   = ST_WR1;
              end else begin
                state_d = ST_DONE;
              end
            end
            OP_CLEAR: begin
              sweep_d = '0;
              state_d = ST_CLR;
            end
            OP_READ: begin
              ram_re    = 1'b1;
              ram_raddr = q_addr;
              state_d   = ST_RDWAIT;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_RD0: begin
        ram_we    = 1'b1;
        ram_waddr = cmd_addr;
        ram_wdata = (ram_rdata & ~cmd_q.wmask[15:8]) | (cmd_q.wdata[15:8] & cmd_q.wmask[15:8]);
        if (cmd_q.wmask[7:0] != 8'h00) begin
          ram_re    = 1'b1;
          ram_raddr = cmd_addr + 1'b1;
          state_d   = ST_WR1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = cmd_addr + 1'b1;
        ram_wdata = (ram_rdata & ~cmd_q.wmask[7:0]) | (cmd_q.wdata[7:0] & cmd_q.wmask[7:0]);
        state_d   = ST_DONE;
      end
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = cmd_q.wdata[15:8];
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == LastAddr) begin
          sweep_d = '0;
          state_d = ST_DONE;
        end
      end
      ST_RDWAIT: begin
        res_d.read_data = ram_rdata;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  `MFB_ASSERT_IMP(a_init_no_pop, state_q == ST_INIT, !q_pop_o, "command taken during init")
  `MFB_ASSERT_IMP(a_idle_no_write, state_q == ST_IDLE, !ram_we, "store written while idle")
  `MFB_ASSERT_IMP(a_rd0_has_mask, state_q == ST_RD0, cmd_q.wmask[15:8] != 8'h00,
                  "first byte merge with empty mask")
  `MFB_ASSERT_NXT(a_done_emits, (state_q == ST_DONE) && res_ready, out_valid_q,
                  "finished command gave no result")

endmodule

// ===== hw/rtl/mono_framebuffer_blitter.sv =====
// path from accept to result: the front stage register, a queue slot, then the back end's states:
//   blit reads and rewrites each byte with a set mask (RD0, WR1), read waits in RDWAIT, clear
//   sweeps the store writing one byte per cycle, and every item ends in DONE, which registers the result
// the back end takes a new item only after DONE, and DONE waits while a held result is stalled
// reset: after rst_ni rises the store's ROW_BYTES * DISP_HEIGHT bytes (48000 at 800x480) are filled
//   with 0xFF and no input beat is taken until that is done
module mono_framebuffer_blitter
  import mfb_pkg::*;
#(
  parameter int DISP_WIDTH  = DISP_WIDTH_DEF,
  parameter int DISP_HEIGHT = DISP_HEIGHT_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mfb_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output mfb_out_t out_data_o
);

  localparam int RowBytes   = (DISP_WIDTH + 7) / 8;
  localparam int StoreBytes = RowBytes * DISP_HEIGHT;

  mfb_status_t status;
  logic        push;
  logic        full;
  mfb_cmd_t    push_cmd;
  logic        q_valid;
  logic        q_pop;
  mfb_cmd_t    q_cmd;

  mfb_front #(
    .DISP_WIDTH  (DISP_WIDTH),
    .DISP_HEIGHT (DISP_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .status_i   (status),
    .push_o     (push),
    .full_i     (full),
    .cmd_o      (push_cmd)
  );

  mfb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd)
  );

  mfb_back #(
    .STORE_BYTES (StoreBytes)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_cmd),
    .q_pop_o     (q_pop),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sim/tb.sv =====
module tb;
  import mfb_pkg::*;

  localparam int ROW_BYTES   = (DISP_WIDTH_DEF + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * DISP_HEIGHT_DEF;
  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_ITEMS   = 60;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  class frame_scoreboard;
    logic [7:0] frame_copy [STORE_BYTES];
    mfb_out_t   due_results [$];
    int errors, checked, blits, reads, clears, unused, pixels_painted;

    function new();
      foreach (frame_copy[k]) frame_copy[k] = FILL_WHITE;
      errors = 0;
      checked = 0;
      blits = 0;
      reads = 0;
      clears = 0;
      unused = 0;
      pixels_painted = 0;
    endfunction

    function logic [3:0] paint_byte(mfb_in_t it);
      int unsigned py, col, px, idx, cnt;
      logic [7:0] mask;
      cnt = 0;
      py = 32'(it.dest_y) + 32'(it.src_row);
      if (it.src_row >= it.img_height || py >= DISP_HEIGHT_DEF) return 4'd0;
      for (int i = 0; i < 8; i++) begin
        col = 32'(it.src_byte_col) * 8 + i;
        px = 32'(it.dest_x) + col;
        if (col < 32'(it.img_width) && px < DISP_WIDTH_DEF) begin
          idx = py * ROW_BYTES + (px >> 3);
          if (idx < STORE_BYTES) begin
            mask = 8'h80 >> (px & 7);
            if (it.data_byte[7 - i]) frame_copy[idx] = frame_copy[idx] | mask;
            else frame_copy[idx] = frame_copy[idx] & ~mask;
            cnt++;
          end
        end
      end
      return 4'(cnt);
    endfunction

    function void accept_request(mfb_in_t it);
      mfb_out_t res;
      res = '0;
      case (it.req_type)
        REQ_BLIT: begin
          res.pixels_drawn = paint_byte(it);
          blits++;
          pixels_painted += res.pixels_drawn;
        end
        REQ_CLEAR: begin
          foreach (frame_copy[k]) frame_copy[k] = it.data_byte;
          clears++;
        end
        REQ_READ: begin
          if (it.read_addr < STORE_BYTES) res.read_data = frame_copy[it.read_addr];
          reads++;
        end
        default: unused++;
      endcase
      due_results.push_back(res);
    endfunction

    function void check_response(mfb_out_t got);
      mfb_out_t exp;
      if (due_results.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual read_data %02h pixels_drawn %0d",
                 $time, got.read_data, got.pixels_drawn);
        errors++;
        return;
      end
      exp = due_results.pop_front();
      checked++;
      if (got.read_data !== exp.read_data) begin
        $display("%0t read_data mismatch: expected %02h, actual %02h",
                 $time, exp.read_data, got.read_data);
        errors++;
      end
      if (got.pixels_drawn !== exp.pixels_drawn) begin
        $display("%0t pixels_drawn mismatch: expected %0d, actual %0d",
                 $time, exp.pixels_drawn, got.pixels_drawn);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  mfb_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  mfb_out_t out_data_o;

  frame_scoreboard sb = new();
  int sent = 0;
  bit quiet = 1'b0;

  mono_framebuffer_blitter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic mfb_in_t random_item();
    mfb_in_t it;
    it.req_type     = 2'($urandom_range(0, 3));
    it.dest_x       = 16'($urandom);
    it.dest_y       = 16'($urandom);
    it.img_width    = 16'($urandom);
    it.img_height   = 16'($urandom);
    it.src_row      = 16'($urandom);
    it.src_byte_col = 13'($urandom);
    it.data_byte    = 8'($urandom);
    it.read_addr    = 16'($urandom);
    return it;
  endfunction

  task automatic send_beat(input mfb_in_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.accept_request(it);
    sent++;
  endtask

  task automatic blit(input int unsigned dx, dy, w, h, row, bcol, input logic [7:0] data);
    mfb_in_t it;
    it = random_item();
    it.req_type     = REQ_BLIT;
    it.dest_x       = 16'(dx);
    it.dest_y       = 16'(dy);
    it.img_width    = 16'(w);
    it.img_height   = 16'(h);
    it.src_row      = 16'(row);
    it.src_byte_col = 13'(bcol);
    it.data_byte    = data;
    send_beat(it);
  endtask

  task automatic read_byte(input int unsigned addr);
    mfb_in_t it;
    it = random_item();
    it.req_type  = REQ_READ;
    it.read_addr = 16'(addr);
    send_beat(it);
  endtask

  task automatic clear_fill(input logic [7:0] fill);
    mfb_in_t it;
    it = random_item();
    it.req_type  = REQ_CLEAR;
    it.data_byte = fill;
    send_beat(it);
  endtask

  // image sent byte by byte, then one to four bytes read back (a random address where the pick is off screen)
  task automatic draw_image();
    int unsigned dx, dy, w, h, px, py;
    dx = ($urandom_range(0, 3) == 0) ? $urandom_range(780, 805) : $urandom_range(0, 799);
    dy = ($urandom_range(0, 3) == 0) ? $urandom_range(474, 482) : $urandom_range(0, 479);
    w = $urandom_range(1, 40);
    h = $urandom_range(1, 5);
    for (int unsigned r = 0; r < h; r++) begin
      for (int unsigned bc = 0; bc < (w + 7) / 8; bc++) blit(dx, dy, w, h, r, bc, 8'($urandom));
    end
    if ($urandom_range(0, 4) == 0) blit(dx, dy, w, h, h, 0, 8'($urandom));
    if ($urandom_range(0, 4) == 0) blit(dx, dy, w, h, 0, (w + 7) / 8, 8'($urandom));
    repeat ($urandom_range(1, 4)) begin
      py = dy + $urandom_range(0, h - 1);
      px = dx + $urandom_range(0, w - 1);
      if (px < DISP_WIDTH_DEF && py < DISP_HEIGHT_DEF) read_byte(py * ROW_BYTES + (px >> 3));
      else read_byte($urandom_range(0, STORE_BYTES - 1));
    end
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_response(out_data_o);
  end

  initial begin
    mfb_in_t it;
    int base, pick, clears_left;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset contents, read range, clipping edges, unaligned, padding, no wrap
    read_byte(0);
    read_byte(STORE_BYTES - 1);
    read_byte(STORE_BYTES);
    read_byte(16'hFFFF);
    blit(0, 0, 8, 1, 0, 0, 8'h00);
    blit(3, 0, 16, 1, 0, 0, 8'hA5);
    blit(796, 479, 16, 2, 0, 0, 8'h0F);
    blit(0, 479, 8, 2, 1, 0, 8'h00);
    blit(8, 1, 0, 1, 0, 0, 8'h00);
    blit(8, 1, 8, 0, 0, 0, 8'h00);
    blit(16, 1, 5, 1, 0, 0, 8'h00);
    blit(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 13'h1FFF, 8'hFF);
    blit(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 8'h00);
    blit(0, 0, 16'hFFFF, 16'hFFFF, 0, 13'h1FFF, 8'h00);
    blit(792, 2, 8, 1, 0, 0, 8'h3C);
    read_byte(1);
    read_byte(ROW_BYTES - 1);
    read_byte(2 * ROW_BYTES + ROW_BYTES - 1);
    it = random_item();
    it.req_type = REQ_UNUSED;
    send_beat(it);
    clear_fill(8'h00);
    read_byte(12345);
    blit(5, 7, 8, 1, 0, 0, 8'hFF);
    read_byte(7 * ROW_BYTES);
    read_byte(7 * ROW_BYTES + 1);

    base = sent;
    clears_left = 2;
    while (sent < base + RANDOM_ITEMS) begin
      if (sent >= base + RANDOM_ITEMS - CALM_ITEMS) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 70) draw_image();
      else if (pick < 82) read_byte($urandom_range(0, STORE_BYTES - 1));
      else if (pick < 98) begin
        it = random_item();
        if (it.req_type == REQ_CLEAR) it.req_type = REQ_UNUSED;
        send_beat(it);
      end else if (clears_left > 0) begin
        clear_fill(8'($urandom));
        clears_left--;
      end
    end
    in_valid_i <= 1'b0;

    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("covered %0d blits (%0d pixels written), %0d reads, %0d clears, %0d unused codes",
             sb.blits, sb.pixels_painted, sb.reads, sb.clears, sb.unused);
    $display("%0d result beats checked, %0d errors", sb.checked, sb.errors);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #24_000_000;
    $display("timeout with %0d results outstanding", sb.due_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== mono_framebuffer_blitter.f =====
+incdir+hw/rtl
hw/rtl/mfb_pkg.sv
hw/rtl/mfb_ram.sv
hw/rtl/mfb_front.sv
hw/rtl/mfb_queue.sv
hw/rtl/mfb_back.sv
hw/rtl/mono_framebuffer_blitter.sv
sim/tb.sv
